// File: sv/wmc_pkg.sv
// ----------------------------------------------------------------------------
// wmc_pkg
// Shared constants and types for the windowed midpoint crossover signal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmc_pkg;

    localparam int PRICE_W       = 32;
    localparam int HISTORY_DEPTH = 32;
    localparam int HIST_AW       = 5;
    localparam int SHORT_SPAN    = 9;
    localparam int LONG_SPAN     = 26;
    localparam int SEEN_W        = 6;
    localparam int PERIOD_W      = 6;
    localparam int SUM_W         = PRICE_W + HIST_AW;
    localparam int PL_W          = PRICE_W + 1;
    localparam int QUEUE_DEPTH   = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_AVG_LEN    = 2'd0;
    localparam logic [1:0] CFG_MIN_SEED   = 2'd1;
    localparam logic [1:0] CFG_MAX_SEED   = 2'd2;

    localparam logic [PERIOD_W-1:0] AVG_LEN_RST    = 6'd4;
    localparam logic [PRICE_W-1:0]  MIN_SEED_RST   = 32'd50331648;
    localparam logic [PRICE_W-1:0]  MAX_SEED_RST   = 32'd0;

    typedef struct packed {
        logic [PERIOD_W-1:0] avg_len;
        logic [PRICE_W-1:0]  min_seed;
        logic [PRICE_W-1:0]  max_seed;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
    } t_head;

endpackage

`default_nettype wire

// File: sv/wmc_ram.sv
// ----------------------------------------------------------------------------
// wmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/wmc_front.sv
// ----------------------------------------------------------------------------
// wmc_front
// Input side: accepts price items into a short queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmc_front import wmc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [PRICE_W-1:0] i_close_price,
    output t_head                   o_head,
    input  wire logic               i_pop
);

    logic [PRICE_W-1:0] r_slot [QUEUE_DEPTH];
    logic               r_wr, r_rd;
    logic [1:0]         r_count;
    logic               push, pop;

    assign o_in_ready  = (r_count != 2'(QUEUE_DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.price = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_close_price;
        end
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// File: sv/wmc_back.sv
// ----------------------------------------------------------------------------
// wmc_back
// Back end: history update, window scan, average divide, entry machines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmc_back import wmc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_head                   i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [PRICE_W-1:0]      o_tenkan,
    output logic [PRICE_W-1:0]      o_kijun,
    output logic [PRICE_W-1:0]      o_average,
    output logic                    o_pl_valid,
    output logic signed [PL_W-1:0]  o_pl_amount,
    output logic                    o_pl_from_long
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          r_state;
    logic [HIST_AW-1:0]  r_wp;
    logic [SEEN_W-1:0]   r_seen;
    logic [PRICE_W-1:0]  r_price, r_avg_hold;
    logic [HIST_AW:0]    r_k;
    logic [HIST_AW-1:0]  r_kd;
    logic                r_rdv;
    logic [PRICE_W-1:0]  r_s_hi, r_s_lo, r_l_hi, r_l_lo;
    logic [SUM_W-1:0]    r_sum;
    logic [PERIOD_W:0]   r_rem;
    logic [SEEN_W-1:0]   r_cnt;
    logic [2:0]          r_lstg, r_sstg;
    logic                r_lopen, r_sopen;
    logic [PRICE_W-1:0]  r_lentry, r_sentry;

    logic [HIST_AW-1:0]  n_wp;
    logic [PRICE_W-1:0]  rdata;
    logic [PERIOD_W-1:0] per;
    logic                avg_upd, load;
    logic [PERIOD_W:0]   trial;
    logic [PRICE_W-1:0]  ts, ks, sma;
    logic [2:0]          n_lstg, n_sstg;
    logic                n_lopen, n_sopen, plv, pll;
    logic [PRICE_W-1:0]  n_lentry, n_sentry;
    logic signed [PL_W-1:0] pl;

    assign o_pop = (r_state == S_IDLE) && i_head.valid;
    assign n_wp  = (r_seen != '0) ? r_wp + HIST_AW'(1) : r_wp;

    wmc_ram #(.WIDTH(PRICE_W), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (o_pop),
        .i_waddr (n_wp),
        .i_wdata (i_head.price),
        .i_raddr (r_wp - r_k[HIST_AW-1:0]),
        .o_rdata (rdata)
    );

    assign per     = (i_cfg.avg_len == '0) ? PERIOD_W'(1) : i_cfg.avg_len;
    assign avg_upd = ({1'b0, per} <= (PERIOD_W+1)'(HISTORY_DEPTH))
                     && (r_seen >= per);
    assign trial   = {r_rem[PERIOD_W-1:0], r_sum[SUM_W-1]};
    assign load    = (r_state == S_OUT) && (!o_out_valid || i_out_ready);

    // indicators and the two entry machines, checks in fixed order
    always_comb begin
        logic [PRICE_W:0] s_add, l_add;
        logic act;
        s_add = {1'b0, r_s_hi} + {1'b0, r_s_lo};
        l_add = {1'b0, r_l_hi} + {1'b0, r_l_lo};
        ts  = (r_seen >= SEEN_W'(SHORT_SPAN)) ? s_add[PRICE_W:1] : '0;
        ks  = (r_seen >= SEEN_W'(LONG_SPAN))  ? l_add[PRICE_W:1] : '0;
        sma = avg_upd ? r_sum[PRICE_W-1:0] : r_avg_hold;
        act = (ts != '0) && (ks != '0) && (sma != '0);
        n_lstg = r_lstg;  n_lopen = r_lopen;  n_lentry = r_lentry;
        n_sstg = r_sstg;  n_sopen = r_sopen;  n_sentry = r_sentry;
        plv = 1'b0;  pll = 1'b0;  pl = '0;
        if (act) begin
            if (!r_lopen) begin
                if (ks < ts && ts < sma && n_lstg[2]) begin
                    n_lstg[2] = 1'b0;  n_lopen = 1'b1;  n_lentry = r_price;
                end
                if (ts < ks && ks < sma && n_lstg[1]) begin
                    n_lstg[1] = 1'b0;  n_lstg[2] = 1'b1;
                end
                if (ts < sma && sma < ks && n_lstg[0]) begin
                    n_lstg[0] = 1'b0;  n_lstg[1] = 1'b1;
                end
                if (sma < ts && ts < ks) n_lstg[0] = 1'b1;
            end else if (ks > ts) begin
                n_lopen = 1'b0;
                pl  = $signed({1'b0, r_lentry}) - $signed({1'b0, r_price});
                plv = 1'b1;  pll = 1'b1;
            end
            if (!r_sopen) begin
                if (ks > ts && ts > sma && n_sstg[2]) begin
                    n_sstg[2] = 1'b0;  n_sopen = 1'b1;  n_sentry = r_price;
                end
                if (ts > ks && ks > sma && n_sstg[1]) begin
                    n_sstg[1] = 1'b0;  n_sstg[2] = 1'b1;
                end
                if (ts > sma && sma > ks && n_sstg[0]) begin
                    n_sstg[0] = 1'b0;  n_sstg[1] = 1'b1;
                end
                if (sma > ts && ts > ks) n_sstg[0] = 1'b1;
            end else if (ks < ts) begin
                n_sopen = 1'b0;
                pl  = $signed({1'b0, r_price}) - $signed({1'b0, r_sentry});
                plv = 1'b1;  pll = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_seen     <= '0;
            r_avg_hold <= '0;
            r_lstg     <= '0;
            r_sstg     <= '0;
            r_lopen    <= 1'b0;
            r_sopen    <= 1'b0;
            r_lentry   <= '0;
            r_sentry   <= '0;
            r_rdv      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_wp    <= n_wp;
                        r_price <= i_head.price;
                        if (r_seen != SEEN_W'(HISTORY_DEPTH)) r_seen <= r_seen + 1'b1;
                        r_s_hi <= i_cfg.max_seed;  r_s_lo <= i_cfg.min_seed;
                        r_l_hi <= i_cfg.max_seed;  r_l_lo <= i_cfg.min_seed;
                        r_sum  <= '0;
                        r_k    <= '0;
                        r_rdv  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rdv <= (r_k != (HIST_AW+1)'(HISTORY_DEPTH));
                    r_kd  <= r_k[HIST_AW-1:0];
                    if (r_k != (HIST_AW+1)'(HISTORY_DEPTH)) r_k <= r_k + 1'b1;
                    if (r_rdv) begin
                        if (r_kd < HIST_AW'(SHORT_SPAN)) begin
                            if (rdata > r_s_hi) r_s_hi <= rdata;
                            if (rdata < r_s_lo) r_s_lo <= rdata;
                        end
                        if (r_kd < HIST_AW'(LONG_SPAN)) begin
                            if (rdata > r_l_hi) r_l_hi <= rdata;
                            if (rdata < r_l_lo) r_l_lo <= rdata;
                        end
                        if ({1'b0, r_kd} < per) r_sum <= r_sum + SUM_W'(rdata);
                        if (r_kd == HIST_AW'(HISTORY_DEPTH - 1)) begin
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (trial >= {1'b0, per}) begin
                        r_rem <= trial - {1'b0, per};
                        r_sum <= {r_sum[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_sum <= {r_sum[SUM_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SEEN_W'(SUM_W - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (load) begin
                        r_avg_hold <= sma;
                        r_lstg <= n_lstg;  r_lopen <= n_lopen;  r_lentry <= n_lentry;
                        r_sstg <= n_sstg;  r_sopen <= n_sopen;  r_sentry <= n_sentry;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_tenkan       <= ts;
            o_kijun        <= ks;
            o_average      <= sma;
            o_pl_valid     <= plv;
            o_pl_amount    <= pl;
            o_pl_from_long <= pll;
        end
    end

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(HISTORY_DEPTH)) else $error("history count overflow");
    a_long_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lopen |-> !r_lstg[2]) else $error("long stage set while open");
    a_short_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sopen |-> !r_sstg[2]) else $error("short stage set while open");
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside output step");

endmodule

`default_nettype wire

// File: sv/windowed_midpoint_crossover_signal.sv
// ----------------------------------------------------------------------------
// windowed_midpoint_crossover_signal
// Midpoint and moving-average crossover signal generator over price items.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one close price per item,
//    unsigned Q8.24. A two-entry queue takes items while the back end works.
//  - Output channel (o_out_valid / i_out_ready): exactly one result item per
//    input item, in order: tenkan, kijun, average and the profit/loss report.
//  - Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//    the averaging length, 1 min_seed, 2 max_seed; other indexes are ignored.
//    Write only while the block is idle.
//  - Timing: each item passes through the back end in order: pop and write
//    the history RAM, scan all 32 history entries through the RAM's
//    registered read port, run the bit-serial average divide, then run the
//    entry machines and load the output register. The back end takes the next
//    item only after loading the last result; the queue holds items meanwhile.
//  - Reset (synchronous, active low) clears the queue, counters, positions
//    and configuration to defaults. The history RAM is not cleared.
//  - A stalled receiver holds the result; the back end then waits in its
//    output step and the queue fills, after which o_in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_midpoint_crossover_signal import wmc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [PRICE_W-1:0]   i_close_price,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [PRICE_W-1:0]        o_tenkan,
    output logic [PRICE_W-1:0]        o_kijun,
    output logic [PRICE_W-1:0]        o_average,
    output logic                      o_pl_valid,
    output logic signed [PL_W-1:0]    o_pl_amount,
    output logic                      o_pl_from_long,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [PRICE_W-1:0]   i_cfg_data
);

    t_cfg  r_cfg;
    t_head head;
    logic  pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.avg_len    <= AVG_LEN_RST;
            r_cfg.min_seed   <= MIN_SEED_RST;
            r_cfg.max_seed   <= MAX_SEED_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AVG_LEN:    r_cfg.avg_len    <= i_cfg_data[PERIOD_W-1:0];
                CFG_MIN_SEED:   r_cfg.min_seed   <= i_cfg_data;
                CFG_MAX_SEED:   r_cfg.max_seed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: item queue
    wmc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_close_price (i_close_price),
        .o_head        (head),
        .i_pop         (pop)
    );

    // back: history, indicators, entry machines, output register
    wmc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tenkan       (o_tenkan),
        .o_kijun        (o_kijun),
        .o_average      (o_average),
        .o_pl_valid     (o_pl_valid),
        .o_pl_amount    (o_pl_amount),
        .o_pl_from_long (o_pl_from_long)
    );

endmodule

`default_nettype wire
